// ===== sv/ftd_pkg.sv =====
// Shared types, widths and constants of the force/torque decoupling block.
// Holds the token that travels along the cell chain and both decoupling matrices.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ftd_pkg;

  localparam int NUM_CH       = 6;
  localparam int ADC_BITS     = 16;
  localparam int ADC_FIELD_W  = 16;
  localparam int OFFS_FIELD_W = 16;
  localparam int SCALE_W      = 21;
  localparam int CAL_SHIFT    = 8;
  localparam int OUT_SHIFT    = 16;
  localparam int OUT_W        = 32;
  localparam int COEF_W       = 26;
  localparam int HALF         = NUM_CH / 2;

  localparam int MODEL_W      = 2;
  localparam int OFFS_REG_W   = HALF * OFFS_FIELD_W;
  localparam int SCALE_REG_W  = HALF * SCALE_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = SCALE_REG_W;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALES_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALES_HIGH    = 3'd4;

  localparam logic [MODEL_W-1:0] MODEL_A = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_B = 2'd1;

  // calibration arithmetic widths
  localparam int ADC_EXT_W  = ADC_BITS + ADC_FIELD_W;
  localparam int DIFF_W     = ADC_BITS + 1;
  localparam int CPROD_W    = DIFF_W + SCALE_W;
  localparam int CRAW_W     = CPROD_W - CAL_SHIFT;
  localparam int CAL_W      = (CRAW_W > OUT_W) ? OUT_W : CRAW_W;
  localparam int ROUND_CAL  = 1 << (CAL_SHIFT - 1);

  // matrix arithmetic widths
  localparam int PROD_W     = COEF_W + CAL_W;
  localparam int ACC_W      = PROD_W + $clog2(NUM_CH);
  localparam int ORAW_W     = ACC_W - OUT_SHIFT;
  localparam int ROUND_OUT  = 1 << (OUT_SHIFT - 1);

  localparam int ROW_W      = $clog2(NUM_CH);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_CH - 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

  localparam int IN_DATA_W  = NUM_CH * ADC_FIELD_W;
  localparam int OUT_DATA_W = NUM_CH * OUT_W;

  typedef logic [NUM_CH-1:0][ADC_FIELD_W-1:0] adc_vec_t;
  typedef logic [NUM_CH-1:0][COEF_W-1:0]      coef_vec_t;
  typedef logic [NUM_CH-1:0][CAL_W-1:0]       cal_vec_t;
  typedef logic [NUM_CH-1:0][OUT_W-1:0]       wrench_t;

  // one matrix row on its way down the chain
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              invalid;
    logic [ACC_W-1:0]  psum;
    coef_vec_t         coefs;
    cal_vec_t          cals;
  } tok_t;

  typedef struct packed {
    logic    invalid;
    wrench_t wrench;
  } result_t;

  function automatic coef_vec_t mk_row(input int c0, input int c1, input int c2,
                                       input int c3, input int c4, input int c5);
    coef_vec_t r;
    r[0] = COEF_W'(c0);
    r[1] = COEF_W'(c1);
    r[2] = COEF_W'(c2);
    r[3] = COEF_W'(c3);
    r[4] = COEF_W'(c4);
    r[5] = COEF_W'(c5);
    return r;
  endfunction

  // decoupling coefficients, units of 1/65536
  function automatic coef_vec_t coef_row(input logic [MODEL_W-1:0] model,
                                         input logic [ROW_W-1:0] row);
    coef_vec_t r;
    r = '0;
    case (model)
      MODEL_A: begin
        case (row)
          3'd0: r = mk_row(21758096, -30704, -64567, 236027, 118289, -31229);
          3'd1: r = mk_row(44985, 21738021, -965, -105808, 300878, 51788);
          3'd2: r = mk_row(262714, 50978, 14972452, 47757, 5912927, -158871);
          3'd3: r = mk_row(396, -10834, 7741, 251606, 933, -5566);
          3'd4: r = mk_row(6002, -1392, -5831, 1045, 250625, -3376);
          3'd5: r = mk_row(-48483, -39549, -4134, -263, 64, 535289);
          default: r = '0;
        endcase
      end
      MODEL_B: begin
        case (row)
          3'd0: r = mk_row(19125, -2194418, -2571, 2028807, -8244, 167);
          3'd1: r = mk_row(4732, -1266872, 19238, -1177109, 18272, 2371383);
          3'd2: r = mk_row(-3507247, -13767, -3559483, -13371, -3445353, -20747);
          3'd3: r = mk_row(-139679, -311, 139197, 1520, -314, -1075);
          3'd4: r = mk_row(-80079, -1191, -81277, 632, 157874, 198);
          3'd5: r = mk_row(-776, 114398, -494, 104984, 633, 106368);
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ftd_front.sv =====
// Front end: configuration registers, per-channel offset and scale, row issue.
// Sends one matrix row token per cycle into the cell chain. Uses ftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftd_front (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire [ftd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [ftd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                             take,
  input  wire ftd_pkg::adc_vec_t          adc,
  output logic                            issue_free,
  output ftd_pkg::tok_t                   tok
);
  import ftd_pkg::*;

  logic [MODEL_W-1:0]     sensor_model;
  logic [OFFS_REG_W-1:0]  zero_offsets_low;
  logic [OFFS_REG_W-1:0]  zero_offsets_high;
  logic [SCALE_REG_W-1:0] channel_scales_low;
  logic [SCALE_REG_W-1:0] channel_scales_high;

  logic [OFFS_FIELD_W-1:0] offs_fld [NUM_CH];
  logic [SCALE_W-1:0]      scl_fld  [NUM_CH];
  logic [ADC_EXT_W-1:0]    offs_ext [NUM_CH];
  logic [ADC_EXT_W-1:0]    cnt_ext  [NUM_CH];
  logic signed [DIFF_W-1:0]  diff   [NUM_CH];
  logic signed [CPROD_W-1:0] mult   [NUM_CH];
  logic signed [CPROD_W-1:0] prod   [NUM_CH];
  logic [CPROD_W-1:0]        rnd    [NUM_CH];
  logic [CRAW_W-1:0]         raw    [NUM_CH];
  cal_vec_t                  cal;

  logic [MODEL_W-1:0] model;
  logic               issuing;
  logic [ROW_W-1:0]   row;
  tok_t               tok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_model        <= '0;
      zero_offsets_low    <= '0;
      zero_offsets_high   <= '0;
      channel_scales_low  <= '0;
      channel_scales_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_MODEL: sensor_model        <= cfg_data[MODEL_W-1:0];
        REG_OFFSETS_LOW:  zero_offsets_low    <= cfg_data[OFFS_REG_W-1:0];
        REG_OFFSETS_HIGH: zero_offsets_high   <= cfg_data[OFFS_REG_W-1:0];
        REG_SCALES_LOW:   channel_scales_low  <= cfg_data[SCALE_REG_W-1:0];
        REG_SCALES_HIGH:  channel_scales_high <= cfg_data[SCALE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // count - offset, times scale, per channel
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (k < HALF) begin
        offs_fld[k] = zero_offsets_low[k*OFFS_FIELD_W +: OFFS_FIELD_W];
        scl_fld[k]  = channel_scales_low[k*SCALE_W +: SCALE_W];
      end else begin
        offs_fld[k] = zero_offsets_high[(k-HALF)*OFFS_FIELD_W +: OFFS_FIELD_W];
        scl_fld[k]  = channel_scales_high[(k-HALF)*SCALE_W +: SCALE_W];
      end
      offs_ext[k] = ADC_EXT_W'(offs_fld[k]);
      cnt_ext[k]  = ADC_EXT_W'(adc[k]);
      diff[k] = $signed({1'b0, cnt_ext[k][ADC_BITS-1:0]})
              - $signed({1'b0, offs_ext[k][ADC_BITS-1:0]});
      mult[k] = diff[k] * $signed({1'b0, scl_fld[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < NUM_CH; k++) prod[k] <= mult[k];
      model <= sensor_model;
    end
  end

  // round half up to Q16.16, saturate if the word is too wide
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      rnd[k] = prod[k] + CPROD_W'(ROUND_CAL);
      raw[k] = rnd[k][CPROD_W-1:CAL_SHIFT];
      if (raw[k][CRAW_W-1:CAL_W-1] != {(CRAW_W-CAL_W+1){raw[k][CRAW_W-1]}})
        cal[k] = {raw[k][CRAW_W-1], {(CAL_W-1){~raw[k][CRAW_W-1]}}};
      else
        cal[k] = raw[k][CAL_W-1:0];
    end
  end

  assign issue_free = !issuing || (row == LAST_ROW);

  always_comb begin
    tok_next.valid   = issuing;
    tok_next.first   = (row == '0);
    tok_next.last    = (row == LAST_ROW);
    tok_next.invalid = (model != MODEL_A) && (model != MODEL_B);
    tok_next.psum    = '0;
    tok_next.coefs   = coef_row(model, row);
    tok_next.cals    = cal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      row     <= '0;
      tok     <= '0;
    end else begin
      tok <= tok_next;
      if (take) begin
        issuing <= 1'b1;
        row     <= '0;
      end else if (issuing && row == LAST_ROW) begin
        issuing <= 1'b0;
      end else if (issuing) begin
        row <= row + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ftd_cell.sv =====
// One multiply-accumulate cell of the decoupling chain.
// Holds one channel's calibrated value and adds its term to each passing row. Uses ftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftd_cell (
  input  wire              clk,
  input  wire              rst,
  input  wire ftd_pkg::tok_t tok_in,
  output ftd_pkg::tok_t    tok_out
);
  import ftd_pkg::*;

  logic [CAL_W-1:0]          cal_hold;
  logic [CAL_W-1:0]          cal_use;
  logic signed [PROD_W-1:0]  mult;
  logic signed [PROD_W-1:0]  a_prod;
  tok_t                      sh;
  tok_t                      a_tok;
  tok_t                      b_next;

  // this cell consumes element 0; the rest move down one place
  always_comb begin
    sh = tok_in;
    for (int k = 0; k < NUM_CH - 1; k++) begin
      sh.coefs[k] = tok_in.coefs[k+1];
      sh.cals[k]  = tok_in.cals[k+1];
    end
    sh.coefs[NUM_CH-1] = '0;
    sh.cals[NUM_CH-1]  = '0;
  end

  // the first row of a word brings the new calibrated value
  assign cal_use = tok_in.first ? tok_in.cals[0] : cal_hold;
  assign mult    = $signed(tok_in.coefs[0]) * $signed(cal_use);

  always_ff @(posedge clk) begin
    if (tok_in.valid && tok_in.first) cal_hold <= tok_in.cals[0];
    a_prod <= mult;
  end

  always_comb begin
    b_next      = a_tok;
    b_next.psum = a_tok.psum + ACC_W'(a_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tok   <= '0;
      tok_out <= '0;
    end else begin
      a_tok   <= sh;
      tok_out <= b_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ftd_collect.sv =====
// Output end: rounds and saturates each row, gathers six rows, queues results.
// Drives the master-side stream. Uses ftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftd_collect (
  input  wire                           clk,
  input  wire                           rst,
  input  wire ftd_pkg::tok_t            tok_in,
  output logic                          out_valid,
  input  wire                           out_ready,
  output ftd_pkg::result_t              out_res
);
  import ftd_pkg::*;

  logic [ACC_W-1:0]  rnd;
  logic [ORAW_W-1:0] raw;
  logic [OUT_W-1:0]  val;

  logic              r_valid;
  logic              r_last;
  logic              r_inv;
  logic [OUT_W-1:0]  r_val;

  wrench_t           rows;
  wrench_t           rows_next;

  result_t              fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp;
  logic [FIFO_AW-1:0]   rp;
  logic [CRED_W-1:0]    fill;
  logic                 push;
  logic                 pop;

  always_comb begin
    rnd = tok_in.psum + ACC_W'(ROUND_OUT);
    raw = rnd[ACC_W-1:OUT_SHIFT];
    if (tok_in.invalid)
      val = '0;
    else if (raw[ORAW_W-1:OUT_W-1] != {(ORAW_W-OUT_W+1){raw[ORAW_W-1]}})
      val = {raw[ORAW_W-1], {(OUT_W-1){~raw[ORAW_W-1]}}};
    else
      val = raw[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      r_last  <= 1'b0;
      r_inv   <= 1'b0;
    end else begin
      r_valid <= tok_in.valid;
      r_last  <= tok_in.last;
      r_inv   <= tok_in.invalid;
    end
  end

  always_ff @(posedge clk) begin
    r_val <= val;
  end

  // row 0 arrives first and ends up in the lowest slot
  always_comb begin
    for (int k = 0; k < NUM_CH - 1; k++) rows_next[k] = rows[k+1];
    rows_next[NUM_CH-1] = r_val;
  end

  always_ff @(posedge clk) begin
    if (r_valid) rows <= rows_next;
  end

  // entry always free: the top level holds back input beyond the queue depth
  assign push = r_valid && r_last;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp].invalid <= r_inv;
      fifo[wp].wrench  <= rows_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      fill <= fill + CRED_W'(push) - CRED_W'(pop);
    end
  end

  assign out_valid = (fill != '0);
  assign out_res   = fifo[rp];

endmodule

`default_nettype wire

// ===== sv/force_torque_decoupling.sv =====
// Six-axis force/torque decoupling: offset, scale, 6x6 matrix, Q16.16 output.
// One matrix row enters the six-cell multiply-accumulate chain per cycle,
// each cell with one multiplier; a new word is accepted as the last row of
// the previous word is issued.
// Up to 4 words may be in flight before tready drops (output queue depth).
// Synchronous reset (rst) zeroes config, control and token registers, emptying the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module force_torque_decoupling (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire [ftd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [ftd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // adc_ch0, adc_ch1, adc_ch2, adc_ch3, adc_ch4, adc_ch5
  input  wire [ftd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  output logic [ftd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // model_invalid
  output logic                            m_axis_tuser
);
  import ftd_pkg::*;

  logic              take;
  logic              issue_free;
  logic [CRED_W-1:0] credit;
  logic              pop;
  tok_t              chain [NUM_CH+1];
  result_t           res;

  assign s_axis_tready = issue_free && (credit < CRED_W'(FIFO_DEPTH));
  assign take          = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  // words accepted and not yet taken on the master side
  always_ff @(posedge clk) begin
    if (rst)
      credit <= '0;
    else
      credit <= credit + CRED_W'(take) - CRED_W'(pop);
  end

  ftd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .adc        (adc_vec_t'(s_axis_tdata)),
    .issue_free (issue_free),
    .tok        (chain[0])
  );

  for (genvar g = 0; g < NUM_CH; g++) begin : g_cell
    ftd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  ftd_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .tok_in    (chain[NUM_CH]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = res.wrench;
  assign m_axis_tuser = res.invalid;

endmodule

`default_nettype wire
